### src/forb_pkg.sv
package forb_pkg;

    // Default sizing of the sample store
    localparam int DEFAULT_BUFFER_DEPTH = 64;
    localparam int DEFAULT_SAMPLE_BITS  = 64;

    // Field widths on the streams
    localparam int KIND_W      = 2;
    localparam int DATA_W      = 64;
    localparam int LIMIT_W     = 7;
    localparam int POS_W       = 6;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    // Longest read run
    localparam logic [LIMIT_W-1:0] RUN_MAX = LIMIT_W'(64);

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE    = 2'd0,
        KIND_READ     = 2'd1,
        KIND_FREEZE   = 2'd2,
        KIND_UNFREEZE = 2'd3
    } t_kind;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND,
        ST_EMPTY
    } t_state;

endpackage

### src/freezable_overwrite_ring_buffer_core.sv
// Write, freeze and unfreeze items leave the block idle, ready again the next cycle.
// A read item runs, per sample, through a fetch state for the registered store read and a
// send state that holds the result until it is taken; new items wait until the run ends.
// An empty read shows its single result in the cycle after acceptance.
// Synchronous active-low reset clears the pointers, the count and the frozen flag;
// the store contents are not cleared and need no clearing pass.
module freezable_overwrite_ring_buffer_core
    import forb_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH,
    parameter int SAMPLE_BITS  = DEFAULT_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [63:0] sample_data, [70:64] read_limit, [71] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]      s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [63:0] sample_out, [69:64] run_position, [71:70] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    // [0] empty_read
    output logic [0:0]             m_axis_tuser
);

    localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Wrap a store index
    function automatic logic [PTR_W-1:0] f_adv(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(BUFFER_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    logic [SAMPLE_BITS-1:0] r_mem [BUFFER_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_wr_ptr, r_old_ptr, r_idx;
    logic [CNT_W-1:0] r_fill;
    logic             r_frozen;
    logic [POS_W-1:0] r_pos, r_last_pos;

    logic               in_acc, out_acc, rd_en, run_last;
    t_kind              in_kind;
    logic [DATA_W-1:0]  in_sample;
    logic [LIMIT_W-1:0] in_limit, lim_sat, run_len;

    assign in_acc    = s_axis_tvalid & s_axis_tready;
    assign out_acc   = m_axis_tvalid & m_axis_tready;
    assign in_kind   = t_kind'(s_axis_tuser);
    assign in_sample = s_axis_tdata[DATA_W-1:0];
    assign in_limit  = s_axis_tdata[DATA_W +: LIMIT_W];
    assign run_last  = (r_pos == r_last_pos);

    // Clamp the read length to the run limit and the fill level
    always_comb begin
        lim_sat = (in_limit > RUN_MAX) ? RUN_MAX : in_limit;
        if (CMP_W'(r_fill) < CMP_W'(lim_sat)) begin
            run_len = LIMIT_W'(r_fill);
        end else begin
            run_len = lim_sat;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && in_kind == KIND_READ) begin
                    n_state = (run_len == '0) ? ST_EMPTY : ST_FETCH;
                end
            end
            ST_FETCH: n_state = ST_SEND;
            ST_SEND: begin
                if (out_acc) begin
                    n_state = run_last ? ST_IDLE : ST_FETCH;
                end
            end
            ST_EMPTY: begin
                if (out_acc) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        rd_en         = 1'b0;
        m_axis_tdata  = '0;
        m_axis_tlast  = 1'b0;
        m_axis_tuser  = 1'b0;
        unique case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_FETCH: rd_en = 1'b1;
            ST_SEND: begin
                m_axis_tvalid                 = 1'b1;
                m_axis_tdata[DATA_W-1:0]      = DATA_W'(r_rd_data);
                m_axis_tdata[DATA_W +: POS_W] = r_pos;
                m_axis_tlast                  = run_last;
            end
            ST_EMPTY: begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = 1'b1;
                m_axis_tuser  = 1'b1;
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    // Sample store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc && in_kind == KIND_WRITE && !r_frozen) begin
            r_mem[r_wr_ptr] <= in_sample[SAMPLE_BITS-1:0];
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // Pointers, count, freeze flag and run sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wr_ptr   <= '0;
            r_old_ptr  <= '0;
            r_fill     <= '0;
            r_frozen   <= 1'b0;
            r_idx      <= '0;
            r_pos      <= '0;
            r_last_pos <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                case (in_kind)
                    KIND_WRITE: begin
                        if (!r_frozen) begin
                            r_wr_ptr <= f_adv(r_wr_ptr);
                            if (r_fill < CNT_W'(BUFFER_DEPTH)) begin
                                r_fill <= r_fill + CNT_W'(1);
                            end else begin
                                r_old_ptr <= f_adv(r_old_ptr);
                            end
                        end
                    end
                    KIND_READ: begin
                        r_idx      <= r_old_ptr;
                        r_pos      <= '0;
                        r_last_pos <= POS_W'(run_len - LIMIT_W'(1));
                    end
                    KIND_FREEZE: r_frozen <= 1'b1;
                    default: begin
                        r_frozen  <= 1'b0;
                        r_wr_ptr  <= '0;
                        r_old_ptr <= '0;
                        r_fill    <= '0;
                    end
                endcase
            end
            // Advance to the next stored sample of the run
            if (r_state == ST_SEND && out_acc && !run_last) begin
                r_idx <= f_adv(r_idx);
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

endmodule

### src/forb_checker.sv
module forb_assertions
    import forb_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [KIND_W-1:0]      s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic [0:0]             m_axis_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // An empty read is a lone, zeroed, final result
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("malformed empty read result");

    // No new item is taken while a run is being shown
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input ready during a read run");

    // The run ends after its last result
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
        else $error("block busy after last result");

endmodule

bind freezable_overwrite_ring_buffer_core forb_assertions u_forb_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
